@@ sv/bazm_pkg.sv @@
// Package with the shared types and constants of the burst average zone meter.
package bazm_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int TIME_BITS   = 32;
    localparam int SUM_BITS    = 32;
    localparam int COUNT_BITS  = 16;
    localparam int DUR_BITS    = 16;
    localparam int ZONE_BITS   = 3;
    localparam int LEVEL_BITS  = 7;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int NUM_BITS    = 17;
    localparam int ITER_BITS   = 6;

    localparam logic [LEVEL_BITS-1:0]  LEVEL_MAX       = 7'd100;
    localparam logic [SAMPLE_BITS-1:0] LOW_THR_RESET   = 10'd1023;
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE_RESET = 10'd125;
    localparam logic [DUR_BITS-1:0]    MIN_DUR_RESET   = 16'd2000;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_LOW_THR    = 2'd0;
    localparam t_cfg_idx REG_FULL_SCALE = 2'd1;
    localparam t_cfg_idx REG_MIN_DUR    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_AVG,
        S_MAP,
        S_DIV_LVL,
        S_DONE
    } t_state;

endpackage

@@ sv/bazm_in_if.sv @@
// Input channel interface: one timestamped sensor sample per transaction.
interface bazm_in_if;
    import bazm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_BITS-1:0]   now_ms;

    modport source (output valid, output sample, output now_ms, input ready);
    modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

@@ sv/bazm_out_if.sv @@
// Output channel interface: one zone index and burst level per transaction.
interface bazm_out_if;
    import bazm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ZONE_BITS-1:0]  zone_index;
    logic [LEVEL_BITS-1:0] level;

    modport source (output valid, output zone_index, output level, input ready);
    modport sink   (input valid, input zone_index, input level, output ready);
endinterface

@@ sv/burst_average_zone_meter.sv @@
// Top level of the burst average zone meter with its shared iterative divider.
//
// Samples enter on i_in as transactions carrying a 10-bit reading and a
// 32-bit millisecond timestamp. While idle, a nonzero sample opens a burst.
// Later samples above the low threshold are summed and counted, and the first
// sample at or below it closes the burst. A long enough, nonempty burst yields
// one transaction on o_out with the current zone and the average mapped to
// 0..100; the zone then advances modulo ZONES.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data. The
// user must write it only while the block is idle; the block itself does not
// enforce this. Indexes beyond the register list are ignored. A sample that
// does not close a reported burst leaves i_in.ready high. A closing sample
// that gives a result holds i_in.ready low until the result is loaded: 32
// steps of the shared restoring divider for sum/count, the mapping state,
// 17 divider steps for the scaling, and the load of the output register,
// which waits while an earlier result is still unread. When the average
// clamps to 0 or 100 the second division is skipped.
// Synchronous reset restores the register defaults, closes any burst and
// returns zone 0. A finished result is held in the output register while the
// receiver stalls; the block keeps taking samples meanwhile and only waits if
// a second result is ready before the first one was taken.
module burst_average_zone_meter #(
    parameter int ZONES = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bazm_in_if.sink                         i_in,
    bazm_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  bazm_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [bazm_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import bazm_pkg::*;

    localparam logic [ZONE_BITS-1:0] ZONE_LAST = ZONE_BITS'(ZONES - 1);
    localparam logic [ITER_BITS-1:0] AVG_STEPS = ITER_BITS'(SUM_BITS);
    localparam logic [ITER_BITS-1:0] LVL_STEPS = ITER_BITS'(NUM_BITS);

    // Configuration registers.
    logic [SAMPLE_BITS-1:0] r_low_thr;
    logic [SAMPLE_BITS-1:0] r_full_scale;
    logic [DUR_BITS-1:0]    r_min_dur;

    // Control and burst state.
    t_state                 r_state, n_state;
    logic                   r_in_burst, n_in_burst;
    logic [TIME_BITS-1:0]   r_start, n_start;
    logic [SUM_BITS-1:0]    r_sum, n_sum;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic [ZONE_BITS-1:0]   r_zone, n_zone;
    logic [LEVEL_BITS-1:0]  r_level, n_level;

    // Shared restoring divider: quotient shifts in at the bottom of r_quo
    // while the dividend leaves at the top.
    logic [SUM_BITS-1:0]    r_quo, n_quo;
    logic [COUNT_BITS-1:0]  r_rem, n_rem;
    logic [COUNT_BITS-1:0]  r_dvsr, n_dvsr;
    logic [ITER_BITS-1:0]   r_iter, n_iter;

    // Output register.
    logic                   r_out_valid, n_out_valid;
    logic [ZONE_BITS-1:0]   r_out_zone, n_out_zone;
    logic [LEVEL_BITS-1:0]  r_out_level, n_out_level;

    logic                   in_accept;
    logic [SUM_BITS:0]      sum_ext;
    logic [TIME_BITS-1:0]   elapsed;
    logic [COUNT_BITS:0]    div_trial;
    logic                   div_ge;
    logic [COUNT_BITS-1:0]  div_rem;
    logic [SUM_BITS-1:0]    div_quo;
    logic [SAMPLE_BITS-1:0] avg_diff;
    logic [NUM_BITS-1:0]    lvl_num;

    assign i_in.ready       = (r_state == S_IDLE);
    assign in_accept        = i_in.valid && i_in.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.zone_index = r_out_zone;
    assign o_out.level      = r_out_level;

    assign sum_ext = {1'b0, r_sum} + {{(SUM_BITS + 1 - SAMPLE_BITS){1'b0}}, i_in.sample};
    assign elapsed = i_in.now_ms - r_start;

    // One divider step.
    assign div_trial = {r_rem, r_quo[SUM_BITS-1]};
    assign div_ge    = (div_trial >= {1'b0, r_dvsr});
    assign div_rem   = div_ge ? COUNT_BITS'(div_trial - {1'b0, r_dvsr})
                              : div_trial[COUNT_BITS-1:0];
    assign div_quo   = {r_quo[SUM_BITS-2:0], div_ge};

    // Scaled numerator; only used when the average lies strictly inside the
    // threshold..full_scale window, so its low bits hold the whole average.
    assign avg_diff = r_quo[SAMPLE_BITS-1:0] - r_low_thr;
    assign lvl_num  = NUM_BITS'(avg_diff) * NUM_BITS'(LEVEL_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr    <= LOW_THR_RESET;
            r_full_scale <= FULL_SCALE_RESET;
            r_min_dur    <= MIN_DUR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LOW_THR:    r_low_thr    <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_FULL_SCALE: r_full_scale <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_MIN_DUR:    r_min_dur    <= i_cfg_data[DUR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_burst  <= 1'b0;
            r_zone      <= '0;
            r_out_valid <= 1'b0;
            r_iter      <= '0;
        end else begin
            r_state     <= n_state;
            r_in_burst  <= n_in_burst;
            r_zone      <= n_zone;
            r_out_valid <= n_out_valid;
            r_iter      <= n_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start     <= n_start;
        r_sum       <= n_sum;
        r_count     <= n_count;
        r_level     <= n_level;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_dvsr      <= n_dvsr;
        r_out_zone  <= n_out_zone;
        r_out_level <= n_out_level;
    end

    always_comb begin
        n_state     = r_state;
        n_in_burst  = r_in_burst;
        n_start     = r_start;
        n_sum       = r_sum;
        n_count     = r_count;
        n_zone      = r_zone;
        n_level     = r_level;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_dvsr      = r_dvsr;
        n_iter      = r_iter;
        n_out_valid = r_out_valid;
        n_out_zone  = r_out_zone;
        n_out_level = r_out_level;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (!r_in_burst) begin
                        if (i_in.sample != '0) begin
                            n_in_burst = 1'b1;
                            n_start    = i_in.now_ms;
                            n_sum      = '0;
                            n_count    = '0;
                        end
                    end else if (i_in.sample > r_low_thr) begin
                        // Sum and count saturate instead of wrapping.
                        n_sum = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
                        if (r_count != '1) begin
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        n_in_burst = 1'b0;
                        if (elapsed >= {{(TIME_BITS - DUR_BITS){1'b0}}, r_min_dur}
                            && r_count != '0) begin
                            n_quo   = r_sum;
                            n_rem   = '0;
                            n_dvsr  = r_count;
                            n_iter  = AVG_STEPS;
                            n_state = S_DIV_AVG;
                        end
                    end
                end
            end
            S_DIV_AVG: begin
                n_quo  = div_quo;
                n_rem  = div_rem;
                n_iter = r_iter - 1'b1;
                if (r_iter == 1) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                // r_quo holds the burst average here.
                if (r_full_scale <= r_low_thr
                    || r_quo <= {{(SUM_BITS - SAMPLE_BITS){1'b0}}, r_low_thr}) begin
                    n_level = '0;
                    n_state = S_DONE;
                end else if (r_quo >= {{(SUM_BITS - SAMPLE_BITS){1'b0}}, r_full_scale}) begin
                    n_level = LEVEL_MAX;
                    n_state = S_DONE;
                end else begin
                    n_quo   = {lvl_num, {(SUM_BITS - NUM_BITS){1'b0}}};
                    n_rem   = '0;
                    n_dvsr  = COUNT_BITS'(r_full_scale - r_low_thr);
                    n_iter  = LVL_STEPS;
                    n_state = S_DIV_LVL;
                end
            end
            S_DIV_LVL: begin
                n_quo  = div_quo;
                n_rem  = div_rem;
                n_iter = r_iter - 1'b1;
                if (r_iter == 1) begin
                    // The quotient stays below LEVEL_MAX in this branch.
                    n_level = div_quo[LEVEL_BITS-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_zone  = r_zone;
                    n_out_level = r_level;
                    n_zone      = (r_zone == ZONE_LAST) ? '0 : r_zone + 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
